// ===== rtl/core/mct_pkg.sv =====
package mct_pkg;

    localparam int DIM_DEFAULT = 4;
    localparam int FRAC_BITS_DEFAULT = 16;
    localparam int ELEM_W = 32;
    localparam int FIELD_ROWS = 4;
    localparam int PROD_W = 2 * ELEM_W;

    typedef enum logic {
        MODE_LOAD = 1'b0,
        MODE_MUL  = 1'b1
    } mode_t;

    typedef struct packed {
        mode_t                     mode;
        logic [1:0]                column_index;
        logic signed [ELEM_W-1:0]  elem_0;
        logic signed [ELEM_W-1:0]  elem_1;
        logic signed [ELEM_W-1:0]  elem_2;
        logic signed [ELEM_W-1:0]  elem_3;
    } in_item_t;

    typedef struct packed {
        logic [1:0]                product_column;
        logic signed [ELEM_W-1:0]  prod_0;
        logic signed [ELEM_W-1:0]  prod_1;
        logic signed [ELEM_W-1:0]  prod_2;
        logic signed [ELEM_W-1:0]  prod_3;
    } out_item_t;

    typedef struct packed {
        logic       valid;
        mode_t      mode;
        logic [1:0] column_index;
    } tok_ctl_t;

endpackage

// ===== rtl/core/mct_cell.sv =====
module mct_cell #(
    parameter int DIM = mct_pkg::DIM_DEFAULT,
    parameter int ACC_W = mct_pkg::PROD_W + 2,
    parameter int IDX = 0
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  mct_pkg::tok_ctl_t                 up_ctl,
    input  logic signed [mct_pkg::ELEM_W-1:0] up_vec [DIM],
    input  logic signed [ACC_W-1:0]           up_acc [DIM],
    output logic                              up_ready,
    output mct_pkg::tok_ctl_t                 dn_ctl,
    output logic signed [mct_pkg::ELEM_W-1:0] dn_vec [DIM],
    output logic signed [ACC_W-1:0]           dn_acc [DIM],
    input  logic                              dn_ready
);

    // Each cell holds one column of the left factor. A transaction passes through
    // the product stage and then the sum stage of every cell.
    localparam bit REACHABLE = (IDX < 4);
    localparam int PW = mct_pkg::PROD_W;

    logic signed [mct_pkg::ELEM_W-1:0] a_reg [DIM];
    mct_pkg::tok_ctl_t                 p_ctl_reg;
    mct_pkg::tok_ctl_t                 s_ctl_reg;
    logic signed [mct_pkg::ELEM_W-1:0] p_vec_reg [DIM];
    logic signed [mct_pkg::ELEM_W-1:0] s_vec_reg [DIM];
    logic signed [ACC_W-1:0]           p_acc_reg [DIM];
    logic signed [ACC_W-1:0]           s_acc_reg [DIM];
    logic signed [mct_pkg::PROD_W-1:0] prod_reg [DIM];
    logic                              p_ready;
    logic                              s_ready;
    logic                              load_hit;

    assign s_ready  = !s_ctl_reg.valid || dn_ready;
    assign p_ready  = !p_ctl_reg.valid || s_ready;
    assign up_ready = p_ready;

    always_comb
    begin
        load_hit = 1'b0;
        if (REACHABLE)
        begin
            load_hit = up_ctl.valid && p_ready && (up_ctl.mode == mct_pkg::MODE_LOAD)
                       && (up_ctl.column_index == 2'(IDX));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_ctl_reg <= '0;
            s_ctl_reg <= '0;
            for (int r = 0; r < DIM; r++)
            begin
                a_reg[r] <= '0;
            end
        end
        else
        begin
            if (p_ready)
            begin
                p_ctl_reg <= up_ctl;
            end
            if (s_ready)
            begin
                s_ctl_reg <= p_ctl_reg;
            end
            if (load_hit)
            begin
                for (int r = 0; r < DIM; r++)
                begin
                    a_reg[r] <= up_vec[r];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (p_ready)
        begin
            for (int r = 0; r < DIM; r++)
            begin
                p_vec_reg[r] <= up_vec[r];
                p_acc_reg[r] <= up_acc[r];
                prod_reg[r]  <= PW'(a_reg[r]) * PW'(up_vec[IDX]);
            end
        end
        if (s_ready)
        begin
            for (int r = 0; r < DIM; r++)
            begin
                s_vec_reg[r] <= p_vec_reg[r];
                s_acc_reg[r] <= p_acc_reg[r] + ACC_W'(prod_reg[r]);
            end
        end
    end

    assign dn_ctl = s_ctl_reg;
    assign dn_vec = s_vec_reg;
    assign dn_acc = s_acc_reg;

endmodule

// ===== rtl/core/mct_out.sv =====
module mct_out #(
    parameter int DIM = mct_pkg::DIM_DEFAULT,
    parameter int FRAC_BITS = mct_pkg::FRAC_BITS_DEFAULT,
    parameter int ACC_W = mct_pkg::PROD_W + 2
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  mct_pkg::tok_ctl_t       up_ctl,
    input  logic signed [ACC_W-1:0] up_acc [DIM],
    output logic                    up_ready,
    output logic                    res_valid,
    output mct_pkg::out_item_t      res_item,
    input  logic                    res_stall
);

    localparam int EW = mct_pkg::ELEM_W;

    logic                   out_valid_reg;
    mct_pkg::out_item_t     out_reg;
    logic signed [EW-1:0]   sat [mct_pkg::FIELD_ROWS];
    logic signed [ACC_W-1:0] shifted [mct_pkg::FIELD_ROWS];
    logic                   take_mul;

    // The floor shift is an arithmetic right shift of the exact sum.
    always_comb
    begin
        for (int r = 0; r < mct_pkg::FIELD_ROWS; r++)
        begin
            shifted[r] = '0;
            sat[r]     = '0;
            if (r < DIM)
            begin
                shifted[r] = up_acc[r] >>> FRAC_BITS;
                if ((&shifted[r][ACC_W-1:EW-1]) || !(|shifted[r][ACC_W-1:EW-1]))
                begin
                    sat[r] = shifted[r][EW-1:0];
                end
                else if (shifted[r][ACC_W-1])
                begin
                    sat[r] = {1'b1, {(EW-1){1'b0}}};
                end
                else
                begin
                    sat[r] = {1'b0, {(EW-1){1'b1}}};
                end
            end
        end
    end

    assign up_ready = !out_valid_reg || !res_stall;
    assign take_mul = up_ready && up_ctl.valid && (up_ctl.mode == mct_pkg::MODE_MUL);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            out_valid_reg <= up_ctl.valid && (up_ctl.mode == mct_pkg::MODE_MUL);
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_mul)
        begin
            out_reg.product_column <= up_ctl.column_index;
            out_reg.prod_0         <= sat[0];
            out_reg.prod_1         <= sat[1];
            out_reg.prod_2         <= sat[2];
            out_reg.prod_3         <= sat[3];
        end
    end

    assign res_valid = out_valid_reg;
    assign res_item  = out_reg;

endmodule

// ===== rtl/core/mat4_column_transform.sv =====
// Channel   Direction  Handshake                   Payload
// item      in         item_valid / item_stall     mct_pkg::in_item_t
// result    out        result_valid / result_stall mct_pkg::out_item_t
//
// One transaction is accepted per cycle while item_stall is low. A multiply result
// passes through the chain of DIM cells, with a product and a sum stage each,
// and then through the saturating output register.
// Load transactions travel the same chain and write their column when they reach
// the owning cell, so they keep their order with multiplies; they give no result.
// Reset clears the stored matrix at once. Stages move up whenever the stage ahead
// is empty or moving, so a stalled result only blocks the chain as it fills.
module mat4_column_transform #(
    parameter int DIM = mct_pkg::DIM_DEFAULT,
    parameter int FRAC_BITS = mct_pkg::FRAC_BITS_DEFAULT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_stall,
    input  mct_pkg::in_item_t  item,
    output logic               result_valid,
    input  logic               result_stall,
    output mct_pkg::out_item_t result
);

    localparam int ACC_W = mct_pkg::PROD_W + $clog2(DIM);
    localparam int EW = mct_pkg::ELEM_W;

    mct_pkg::tok_ctl_t    ctl   [DIM+1];
    logic signed [EW-1:0] vec   [DIM+1][DIM];
    logic signed [ACC_W-1:0] acc [DIM+1][DIM];
    logic                 ready [DIM+1];
    logic signed [EW-1:0] fields [mct_pkg::FIELD_ROWS];

    assign fields[0] = item.elem_0;
    assign fields[1] = item.elem_1;
    assign fields[2] = item.elem_2;
    assign fields[3] = item.elem_3;

    assign ctl[0].valid        = item_valid;
    assign ctl[0].mode         = item.mode;
    assign ctl[0].column_index = item.column_index;
    assign item_stall          = !ready[0];

    always_comb
    begin
        for (int r = 0; r < DIM; r++)
        begin
            vec[0][r] = '0;
            acc[0][r] = '0;
            if (r < mct_pkg::FIELD_ROWS)
            begin
                vec[0][r] = fields[r];
            end
        end
    end

    for (genvar e = 0; e < DIM; e++)
    begin : g_cell
        mct_cell #(
            .DIM   (DIM),
            .ACC_W (ACC_W),
            .IDX   (e)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .up_ctl   (ctl[e]),
            .up_vec   (vec[e]),
            .up_acc   (acc[e]),
            .up_ready (ready[e]),
            .dn_ctl   (ctl[e+1]),
            .dn_vec   (vec[e+1]),
            .dn_acc   (acc[e+1]),
            .dn_ready (ready[e+1])
        );
    end

    mct_out #(
        .DIM       (DIM),
        .FRAC_BITS (FRAC_BITS),
        .ACC_W     (ACC_W)
    ) u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .up_ctl    (ctl[DIM]),
        .up_acc    (acc[DIM]),
        .up_ready  (ready[DIM]),
        .res_valid (result_valid),
        .res_item  (result),
        .res_stall (result_stall)
    );

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps

module tb;

    import mct_pkg::*;

    localparam int DIM = mct_pkg::DIM_DEFAULT;
    localparam int FRAC = mct_pkg::FRAC_BITS_DEFAULT;
    localparam int LATENCY = 2 * DIM + 1;
    localparam int RANDOM_ITEMS = 1750;
    localparam int CYCLE_LIMIT = 100000;
    localparam int HOLD_START = 800;
    localparam int HOLD_LEN = 250;
    localparam int CALM_START = 1500;
    localparam int CALM_END = 2000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic item_valid = 1'b0;
    logic item_stall;
    in_item_t item = '0;
    logic result_valid;
    logic result_stall = 1'b0;
    out_item_t result;

    in_item_t pend_q[$];
    out_item_t column_q[$];
    logic signed [ELEM_W-1:0] left_mat [DIM*DIM];

    int cycles = 0;
    int hold_cnt = 0;
    int errors = 0;
    int n_loads = 0;
    int n_muls = 0;
    int n_checked = 0;
    logic calm;

    assign calm = (cycles >= CALM_START) && (cycles < CALM_END);

    mat4_column_transform #(
        .DIM(DIM),
        .FRAC_BITS(FRAC)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .item_valid(item_valid),
        .item_stall(item_stall),
        .item(item),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .result(result)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic logic signed [ELEM_W-1:0] elem_of(in_item_t it, int r);
        case (r)
            0: return it.elem_0;
            1: return it.elem_1;
            2: return it.elem_2;
            3: return it.elem_3;
            default: return '0;
        endcase
    endfunction

    function automatic logic signed [ELEM_W-1:0] row_dot(int row, in_item_t it);
        logic signed [79:0] acc;
        logic signed [79:0] sh;
        logic signed [ELEM_W-1:0] ce;
        acc = '0;
        for (int e = 0; e < DIM; e++)
        begin
            ce = elem_of(it, e);
            acc = acc + 80'(left_mat[e*DIM+row]) * 80'(ce);
        end
        sh = acc >>> FRAC;
        if (sh[79:31] == '0 || sh[79:31] == '1)
            return sh[31:0];
        return sh[79] ? 32'h8000_0000 : 32'h7fff_ffff;
    endfunction

    function automatic logic signed [ELEM_W-1:0] prod_row(int row, in_item_t it);
        if (row < DIM)
            return row_dot(row, it);
        return '0;
    endfunction

    task automatic apply_transaction(in_item_t it);
        out_item_t col;
        if (it.mode == MODE_LOAD)
        begin
            n_loads++;
            if (int'(it.column_index) < DIM)
                for (int r = 0; r < DIM; r++)
                    left_mat[int'(it.column_index)*DIM+r] = elem_of(it, r);
        end
        else
        begin
            n_muls++;
            col.product_column = it.column_index;
            col.prod_0 = prod_row(0, it);
            col.prod_1 = prod_row(1, it);
            col.prod_2 = prod_row(2, it);
            col.prod_3 = prod_row(3, it);
            column_q.push_back(col);
        end
    endtask

    task automatic compare_column(out_item_t got);
        out_item_t want;
        if (column_q.size() == 0)
        begin
            errors++;
            $display("%0t: unexpected result, expected none, actual %h", $time, got);
            return;
        end
        want = column_q.pop_front();
        n_checked++;
        if (got.product_column !== want.product_column)
        begin
            errors++;
            $display("%0t: product_column expected %h actual %h", $time,
                     want.product_column, got.product_column);
        end
        if (got.prod_0 !== want.prod_0)
        begin
            errors++;
            $display("%0t: prod_0 expected %h actual %h", $time, want.prod_0, got.prod_0);
        end
        if (got.prod_1 !== want.prod_1)
        begin
            errors++;
            $display("%0t: prod_1 expected %h actual %h", $time, want.prod_1, got.prod_1);
        end
        if (got.prod_2 !== want.prod_2)
        begin
            errors++;
            $display("%0t: prod_2 expected %h actual %h", $time, want.prod_2, got.prod_2);
        end
        if (got.prod_3 !== want.prod_3)
        begin
            errors++;
            $display("%0t: prod_3 expected %h actual %h", $time, want.prod_3, got.prod_3);
        end
    endtask

    function automatic in_item_t mk_item(mode_t m, logic [1:0] c, logic [31:0] e0,
                                         logic [31:0] e1, logic [31:0] e2, logic [31:0] e3);
        in_item_t it;
        it.mode = m;
        it.column_index = c;
        it.elem_0 = e0;
        it.elem_1 = e1;
        it.elem_2 = e2;
        it.elem_3 = e3;
        return it;
    endfunction

    function automatic logic [31:0] rand_elem();
        int pick;
        pick = $urandom_range(99);
        if (pick < 50)
            return $urandom();
        if (pick < 85)
            return 32'(int'($urandom_range(0, 524288)) - 262144);
        case ($urandom_range(5))
            0: return 32'h7fff_ffff;
            1: return 32'h8000_0000;
            2: return 32'h0000_0000;
            3: return 32'h0000_0001;
            4: return 32'hffff_ffff;
            default: return 32'h0001_0000;
        endcase
    endfunction

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("tb NOT OK");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            item_valid <= 1'b0;
            item <= '0;
        end
        else
        begin
            if (item_valid && !item_stall)
                apply_transaction(item);
            if (!item_valid || !item_stall)
            begin
                if (pend_q.size() != 0 && !(!calm && $urandom_range(99) < 9))
                begin
                    item <= pend_q.pop_front();
                    item_valid <= 1'b1;
                end
                else
                    item_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            result_stall <= 1'b0;
        else
        begin
            if (result_valid && !result_stall)
                compare_column(result);
            if (cycles >= HOLD_START && hold_cnt < HOLD_LEN)
            begin
                result_stall <= 1'b1;
                hold_cnt <= hold_cnt + 1;
            end
            else
                result_stall <= !calm && ($urandom_range(99) < 9);
        end
    end

    initial
    begin
        for (int i = 0; i < DIM*DIM; i++)
            left_mat[i] = '0;

        // The stored matrix is all zeros after reset.
        pend_q.push_back(mk_item(MODE_MUL, 2'd0, 32'h7fff_ffff, 32'h8000_0000,
                                 32'h7fff_ffff, 32'h8000_0000));
        for (int c = 0; c < 4; c++)
            pend_q.push_back(mk_item(MODE_LOAD, 2'(c), (c == 0) ? 32'h0001_0000 : 32'h0,
                                     (c == 1) ? 32'h0001_0000 : 32'h0,
                                     (c == 2) ? 32'h0001_0000 : 32'h0,
                                     (c == 3) ? 32'h0001_0000 : 32'h0));
        pend_q.push_back(mk_item(MODE_MUL, 2'd1, 32'h7fff_ffff, 32'h8000_0000,
                                 32'h0000_0001, 32'hffff_ffff));
        pend_q.push_back(mk_item(MODE_MUL, 2'd2, 32'h1234_5678, 32'hedcb_a988,
                                 32'h0001_8000, 32'hfffe_8000));
        pend_q.push_back(mk_item(MODE_MUL, 2'd3, 32'h0, 32'h0, 32'h0, 32'h0));
        for (int c = 0; c < 4; c++)
            pend_q.push_back(mk_item(MODE_LOAD, 2'(c), 32'h7fff_ffff, 32'h7fff_ffff,
                                     32'h7fff_ffff, 32'h7fff_ffff));
        pend_q.push_back(mk_item(MODE_MUL, 2'd0, 32'h7fff_ffff, 32'h7fff_ffff,
                                 32'h7fff_ffff, 32'h7fff_ffff));
        pend_q.push_back(mk_item(MODE_MUL, 2'd1, 32'h8000_0000, 32'h8000_0000,
                                 32'h8000_0000, 32'h8000_0000));
        for (int c = 0; c < 4; c++)
            pend_q.push_back(mk_item(MODE_LOAD, 2'(c), 32'h8000_0000, 32'h8000_0000,
                                     32'hffff_ffff, 32'hffff_ffff));
        pend_q.push_back(mk_item(MODE_MUL, 2'd2, 32'h8000_0000, 32'h8000_0000,
                                 32'h8000_0000, 32'h8000_0000));
        // Small negative sums check that truncation rounds toward minus infinity.
        pend_q.push_back(mk_item(MODE_MUL, 2'd3, 32'h0, 32'h0, 32'h0000_0001,
                                 32'h0000_0001));
        pend_q.push_back(mk_item(MODE_MUL, 2'd0, 32'h0, 32'h0, 32'hffff_ffff,
                                 32'hffff_ffff));

        for (int i = 0; i < RANDOM_ITEMS; i++)
            pend_q.push_back(mk_item(($urandom_range(99) < 30) ? MODE_LOAD : MODE_MUL,
                                     2'($urandom_range(3)), rand_elem(), rand_elem(),
                                     rand_elem(), rand_elem()));

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        while (pend_q.size() != 0 || item_valid)
            @(posedge clk);
        while (column_q.size() != 0)
            @(posedge clk);
        repeat (4 * LATENCY) @(posedge clk);

        if (column_q.size() != 0)
        begin
            errors++;
            $display("%0t: %0d expected results never arrived", $time, column_q.size());
        end
        $display("Covered %0d load and %0d multiply transactions, %0d product columns checked,",
                 n_loads, n_muls, n_checked);
        $display("with random stalls on both sides and a long output hold-off; %0d errors.",
                 errors);
        if (errors == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule
